### hw/rtl/timed_event_queue_macros.svh
// Assertion macros for the timed event queue checker.
// Used by timed_event_queue_chk.sv; expects clk and arst_n in scope.
`ifndef TIMED_EVENT_QUEUE_MACROS_SVH
`define TIMED_EVENT_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TEQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timed_event_queue check failed");

// Next-cycle implication, disabled during reset
`define TEQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timed_event_queue check failed");

`endif

### hw/rtl/teq_pkg.sv
// Package for the timed event queue: sizes, codes, entry and cell control types.
// No dependencies; used by the cell, the top level, the checker and the testbenches.
`timescale 1ns / 1ps
package teq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TIME_BITS   = 48;

	typedef logic [TIME_BITS-1:0] time_t;

	// Input function codes
	localparam logic [2:0] FN_ADD     = 3'd0;
	localparam logic [2:0] FN_REMOVE  = 3'd1;
	localparam logic [2:0] FN_CANCEL  = 3'd2;
	localparam logic [2:0] FN_ADV_TO  = 3'd3;
	localparam logic [2:0] FN_ADV_BY  = 3'd4;

	// Result kind codes
	localparam logic [1:0] KIND_ADDED = 2'd0;
	localparam logic [1:0] KIND_FIRED = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [1:0] KIND_FULL  = 2'd3;

	// One queue entry
	typedef struct packed {
		logic        valid;
		logic        cancelled;
		time_t       deadline;
		logic [31:0] handle;
		logic [7:0]  tag;
		logic [31:0] value;
	} entry_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT,
		OP_COMPACT,
		OP_CLRTAG,
		OP_CANCEL
	} cell_op_t;

	// Broadcast control to every cell
	typedef struct packed {
		cell_op_t    op;
		entry_t      new_e;
		logic [7:0]  tag;
		logic [31:0] handle;
	} cell_ctl_t;

	// Saturating time add
	function automatic time_t sat_add(time_t a, time_t b);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
	endfunction

endpackage

### hw/rtl/teq_in_if.sv
// Input channel of the timed event queue: valid/ready plus command payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface teq_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [7:0]  tag;
	logic [31:0] event_value;
	logic [47:0] time_value;
	logic [31:0] target_handle;

	modport source (output valid, func, tag, event_value, time_value, target_handle,
		input ready);
	modport sink (input valid, func, tag, event_value, time_value, target_handle,
		output ready);
endinterface

### hw/rtl/teq_out_if.sv
// Result channel of the timed event queue: valid/ready plus result payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface teq_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] out_handle;
	logic [7:0]  out_tag;
	logic [31:0] out_value;
	logic [47:0] current_time;
	logic        last;

	modport source (output valid, kind, out_handle, out_tag, out_value, current_time, last,
		input ready);
	modport sink (input valid, kind, out_handle, out_tag, out_value, current_time, last,
		output ready);
endinterface

### hw/rtl/teq_cell.sv
// One cell of the sorted event chain: holds one entry, trades with its neighbors.
// Depends on teq_pkg.
`timescale 1ns / 1ps
module teq_cell
	import teq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    left_e,
	input  entry_t    right_e,
	input  logic      gt_in,
	input  logic      hole_in,
	output entry_t    e,
	output logic      gt_out,
	output logic      hole_out
);

	entry_t e_q;
	entry_t nxt;

	assign e = e_q;

	// Insert point: this entry sorts after the new one (or is empty)
	assign gt_out = !e_q.valid || (e_q.deadline > ctl.new_e.deadline) ||
		(e_q.deadline == ctl.new_e.deadline && e_q.handle > ctl.new_e.handle);
	// A hole at or before this cell
	assign hole_out = hole_in || !e_q.valid;

	always_comb begin
		nxt = e_q;
		case (ctl.op)
			OP_INSERT: begin
				if (gt_out) nxt = gt_in ? left_e : ctl.new_e;
			end
			OP_SHIFT: nxt = right_e;
			OP_COMPACT: begin
				if (hole_out) nxt = right_e;
			end
			OP_CLRTAG: begin
				if (e_q.valid && e_q.tag == ctl.tag) begin
					nxt.valid     = 1'b0;
					nxt.cancelled = 1'b0;
				end
			end
			OP_CANCEL: begin
				if (e_q.valid && e_q.handle == ctl.handle) nxt.cancelled = 1'b1;
			end
			default: nxt = e_q;
		endcase
	end

	// Entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= '0;
		end else begin
			e_q <= nxt;
		end
	end

endmodule

### hw/rtl/timed_event_queue.sv
// Timed event queue top level: command sequencer over a sorted chain of cells.
// Depends on teq_pkg, teq_in_if, teq_out_if, teq_cell.
//
//   channel | dir | transaction
//   req     | in  | func, tag, event_value, time_value, target_handle
//   rsp     | out | kind, out_handle, out_tag, out_value, current_time, last
//
// One command at a time. Add, cancel and unknown codes go from EXEC to FIN, where the result
// is loaded once the output is free; only then is a new command accepted.
// Remove by tag adds the COMPACT state, repeated while a valid entry lies behind a hole.
// Advance to a past time goes from EXEC to FIN like add; otherwise ADV pops each due event first.
// Reset clears the chain, time to 0 and the handle counter to 1; no clearing pass.
// A stalled rsp holds the sequencer only when it has a new result to show.
`timescale 1ns / 1ps
module timed_event_queue
	import teq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	teq_in_if.sink       req,
	teq_out_if.source    rsp
);

	typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_COMPACT, ST_ADV, ST_FIN} state_t;

	state_t      state_q;
	logic [2:0]  func_q;
	logic [7:0]  tag_q;
	logic [31:0] val_q;
	time_t       tv_q;
	logic [31:0] th_q;
	time_t       now_q;
	time_t       target_q;
	logic [31:0] hcnt_q;
	logic [1:0]  res_kind_q;
	logic [31:0] res_handle_q;

	logic        outv_q;
	logic [1:0]  kind_q;
	logic [31:0] handle_q;
	logic [7:0]  otag_q;
	logic [31:0] oval_q;
	time_t       otime_q;
	logic        last_q;

	cell_ctl_t ctl;
	entry_t    cell_e [QUEUE_DEPTH];
	logic      gt   [QUEUE_DEPTH+1];
	logic      hole [QUEUE_DEPTH+1];
	logic [QUEUE_DEPTH-1:0] need;

	logic  out_free;
	logic  out_load;
	logic  full;
	logic  need_compact;
	logic  head_due;
	time_t adv_target;
	entry_t head;

	// Cell chain
	assign gt[0]   = 1'b0;
	assign hole[0] = 1'b0;
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		if (i == 0) begin : g_first
			assign left_e = ctl.new_e;
		end else begin : g_mid
			assign left_e = cell_e[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = cell_e[i+1];
		end
		teq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.left_e  (left_e),
			.right_e (right_e),
			.gt_in   (gt[i]),
			.hole_in (hole[i]),
			.e       (cell_e[i]),
			.gt_out  (gt[i+1]),
			.hole_out(hole[i+1])
		);
		assign need[i] = cell_e[i].valid && hole[i];
	end

	assign head         = cell_e[0];
	assign full         = cell_e[QUEUE_DEPTH-1].valid;
	assign need_compact = |need;
	assign head_due     = head.valid && (head.deadline <= target_q);
	assign out_free     = !outv_q || rsp.ready;
	assign adv_target   = (func_q == FN_ADV_TO) ? tv_q : sat_add(now_q, tv_q);
	// A new result goes into the output register this cycle
	assign out_load     = out_free && ((state_q == ST_FIN) ||
		(state_q == ST_ADV && head_due && !head.cancelled));

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = outv_q;
	assign rsp.kind         = kind_q;
	assign rsp.out_handle   = handle_q;
	assign rsp.out_tag      = otag_q;
	assign rsp.out_value    = oval_q;
	assign rsp.current_time = otime_q;
	assign rsp.last         = last_q;

	// Cell commands
	always_comb begin
		ctl              = '0;
		ctl.op           = OP_HOLD;
		ctl.tag          = tag_q;
		ctl.handle       = th_q;
		ctl.new_e.valid  = 1'b1;
		ctl.new_e.deadline = sat_add(now_q, tv_q);
		ctl.new_e.handle = hcnt_q;
		ctl.new_e.tag    = tag_q;
		ctl.new_e.value  = val_q;
		case (state_q)
			ST_EXEC: begin
				case (func_q)
					FN_ADD:    if (!full) ctl.op = OP_INSERT;
					FN_REMOVE: ctl.op = OP_CLRTAG;
					FN_CANCEL: if (th_q != 32'd0) ctl.op = OP_CANCEL;
					default:   ctl.op = OP_HOLD;
				endcase
			end
			ST_COMPACT: ctl.op = OP_COMPACT;
			ST_ADV: begin
				if (head_due && (head.cancelled || out_free)) ctl.op = OP_SHIFT;
			end
			default: ctl.op = OP_HOLD;
		endcase
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			func_q       <= FN_ADD;
			tag_q        <= '0;
			val_q        <= '0;
			tv_q         <= '0;
			th_q         <= '0;
			now_q        <= '0;
			target_q     <= '0;
			hcnt_q       <= 32'd1;
			res_kind_q   <= KIND_DONE;
			res_handle_q <= '0;
			outv_q       <= 1'b0;
			kind_q       <= KIND_DONE;
			handle_q     <= '0;
			otag_q       <= '0;
			oval_q       <= '0;
			otime_q      <= '0;
			last_q       <= 1'b0;
		end else begin
			if (out_load) outv_q <= 1'b1;
			else if (rsp.ready) outv_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						func_q  <= req.func;
						tag_q   <= req.tag;
						val_q   <= req.event_value;
						tv_q    <= req.time_value;
						th_q    <= req.target_handle;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_kind_q   <= KIND_DONE;
					res_handle_q <= '0;
					state_q      <= ST_FIN;
					case (func_q)
						FN_ADD: begin
							if (full) begin
								res_kind_q <= KIND_FULL;
							end else begin
								res_kind_q   <= KIND_ADDED;
								res_handle_q <= hcnt_q;
								hcnt_q <= (hcnt_q == 32'hFFFF_FFFF) ? 32'd1 : hcnt_q + 32'd1;
							end
						end
						FN_REMOVE: state_q <= ST_COMPACT;
						FN_ADV_TO, FN_ADV_BY: begin
							target_q <= adv_target;
							if (adv_target >= now_q) state_q <= ST_ADV;
						end
						default: state_q <= ST_FIN;
					endcase
				end
				ST_COMPACT: begin
					if (!need_compact) state_q <= ST_FIN;
				end
				ST_ADV: begin
					if (head_due) begin
						if (head.cancelled) begin
							now_q <= head.deadline;
						end else if (out_free) begin
							now_q    <= head.deadline;
							kind_q   <= KIND_FIRED;
							handle_q <= head.handle;
							otag_q   <= head.tag;
							oval_q   <= head.value;
							otime_q  <= head.deadline;
							last_q   <= 1'b0;
						end
					end else begin
						now_q   <= target_q;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						kind_q   <= res_kind_q;
						handle_q <= res_handle_q;
						otag_q   <= '0;
						oval_q   <= '0;
						otime_q  <= now_q;
						last_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/timed_event_queue_chk.sv
// Port-level checker for the timed event queue, bound to the top level.
// Depends on teq_pkg and timed_event_queue_macros.svh.
`timescale 1ns / 1ps
`include "timed_event_queue_macros.svh"
module timed_event_queue_chk
	import teq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_kind,
	input logic [31:0] rsp_handle,
	input logic        rsp_last
);

	// A stalled result keeps its kind
	`TEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind))
	// Fired events are never the closing result
	`TEQ_ASSERT_NOW(a_fired_not_last, rsp_valid && rsp_kind == KIND_FIRED, !rsp_last)
	// Add answers are always the closing result
	`TEQ_ASSERT_NOW(a_add_last, rsp_valid && (rsp_kind == KIND_ADDED || rsp_kind == KIND_FULL), rsp_last)
	// Handles given out or fired are never zero
	`TEQ_ASSERT_NOW(a_handle_nz, rsp_valid && (rsp_kind == KIND_ADDED || rsp_kind == KIND_FIRED), rsp_handle != 32'd0)

endmodule

bind timed_event_queue timed_event_queue_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_kind  (rsp.kind),
	.rsp_handle(rsp.out_handle),
	.rsp_last  (rsp.last)
);

### tb/sv/teq_tb_chk.sv
// Scoreboard for the timed event queue: watches req and rsp, predicts results and compares.
// Depends on teq_pkg, teq_in_if and teq_out_if.
`timescale 1ns / 1ps
module teq_tb_chk
	import teq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	teq_in_if         req,
	teq_out_if        rsp,
	output int        errors,
	output int        pending,
	output int        fired_seen,
	output int        full_seen
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] handle;
		logic [7:0]  tag;
		logic [31:0] value;
		time_t       now;
		logic        last;
	} result_t;

	localparam time_t TIME_MAX = {TIME_BITS{1'b1}};

	// Shadow scheduler state
	logic        q_valid [QUEUE_DEPTH];
	logic        q_cancel[QUEUE_DEPTH];
	time_t       q_dl    [QUEUE_DEPTH];
	logic [31:0] q_handle[QUEUE_DEPTH];
	logic [7:0]  q_tag   [QUEUE_DEPTH];
	logic [31:0] q_value [QUEUE_DEPTH];
	time_t       sched_now;
	logic [31:0] hcnt_model;

	result_t expected_results[$];

	function automatic time_t clamp_sum(time_t a, time_t b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
	endfunction

	function automatic void push_result(logic [1:0] k, logic [31:0] h, logic [7:0] t,
		logic [31:0] v, logic l);
		result_t r;
		r.kind = k; r.handle = h; r.tag = t; r.value = v; r.now = sched_now; r.last = l;
		expected_results.insert(expected_results.size(), r);
	endfunction

	// Pop due events in deadline order, lower handle wins ties
	function automatic void run_to(time_t target);
		int best;
		if (target < sched_now) begin
			push_result(KIND_DONE, 0, 0, 0, 1'b1);
			return;
		end
		forever begin
			best = -1;
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (!q_valid[i] || q_dl[i] > target) continue;
				if (best < 0 || q_dl[i] < q_dl[best] ||
					(q_dl[i] == q_dl[best] && q_handle[i] < q_handle[best]))
					best = i;
			end
			if (best < 0) break;
			q_valid[best] = 1'b0;
			sched_now = q_dl[best];
			if (q_cancel[best]) q_cancel[best] = 1'b0;
			else push_result(KIND_FIRED, q_handle[best], q_tag[best], q_value[best], 1'b0);
		end
		sched_now = target;
		push_result(KIND_DONE, 0, 0, 0, 1'b1);
	endfunction

	function automatic void predict_command(logic [2:0] fn, logic [7:0] tg, logic [31:0] val,
		time_t tv, logic [31:0] th);
		int slot;
		case (fn)
			FN_ADD: begin
				slot = -1;
				for (int i = 0; i < QUEUE_DEPTH; i++)
					if (slot < 0 && !q_valid[i]) slot = i;
				if (slot < 0) push_result(KIND_FULL, 0, 0, 0, 1'b1);
				else begin
					q_valid[slot] = 1'b1; q_cancel[slot] = 1'b0;
					q_dl[slot] = clamp_sum(sched_now, tv);
					q_handle[slot] = hcnt_model; q_tag[slot] = tg; q_value[slot] = val;
					push_result(KIND_ADDED, hcnt_model, 0, 0, 1'b1);
					hcnt_model = (hcnt_model == 32'hFFFF_FFFF) ? 32'd1 : hcnt_model + 32'd1;
				end
			end
			FN_REMOVE: begin
				for (int i = 0; i < QUEUE_DEPTH; i++)
					if (q_valid[i] && q_tag[i] == tg) begin
						q_valid[i] = 1'b0; q_cancel[i] = 1'b0;
					end
				push_result(KIND_DONE, 0, 0, 0, 1'b1);
			end
			FN_CANCEL: begin
				if (th != 0)
					for (int i = 0; i < QUEUE_DEPTH; i++)
						if (q_valid[i] && q_handle[i] == th) q_cancel[i] = 1'b1;
				push_result(KIND_DONE, 0, 0, 0, 1'b1);
			end
			FN_ADV_TO: run_to(tv);
			FN_ADV_BY: run_to(clamp_sum(sched_now, tv));
			default: push_result(KIND_DONE, 0, 0, 0, 1'b1);
		endcase
	endfunction

	// Predict on accepted commands, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		result_t got, exp_r;
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				q_valid[i] = 1'b0; q_cancel[i] = 1'b0;
			end
			sched_now = '0;
			hcnt_model = 32'd1;
			errors <= 0;
			pending <= 0;
			fired_seen <= 0;
			full_seen <= 0;
			expected_results.delete();
		end else begin
			if (req.valid && req.ready)
				predict_command(req.func, req.tag, req.event_value, req.time_value,
					req.target_handle);
			if (rsp.valid && rsp.ready) begin
				got.kind = rsp.kind; got.handle = rsp.out_handle; got.tag = rsp.out_tag;
				got.value = rsp.out_value; got.now = rsp.current_time; got.last = rsp.last;
				if (got.kind == KIND_FIRED) fired_seen <= fired_seen + 1;
				if (got.kind == KIND_FULL) full_seen <= full_seen + 1;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result kind=%0d handle=%0d", $time,
						got.kind, got.handle);
					errors <= errors + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch expected kind=%0d handle=%0d tag=%0d value=%0h now=%0h last=%0b",
							$time, exp_r.kind, exp_r.handle, exp_r.tag, exp_r.value,
							exp_r.now, exp_r.last);
						$display("%0t:          actual   kind=%0d handle=%0d tag=%0d value=%0h now=%0h last=%0b",
							$time, got.kind, got.handle, got.tag, got.value, got.now, got.last);
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

### tb/sv/timed_event_queue_tb.sv
// Testbench top for the timed event queue: clock, reset, command stimulus and verdict.
// Depends on teq_pkg, teq_in_if, teq_out_if, timed_event_queue and teq_tb_chk.
`timescale 1ns / 1ps
module timed_event_queue_tb;
	import teq_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors, pending, fired_seen, full_seen;
	int   sent = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	bit   long_hold = 0;
	int   quiet_cycles = 0;

	teq_in_if  req();
	teq_out_if rsp();

	timed_event_queue dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	teq_tb_chk chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .errors(errors),
		.pending(pending), .fired_seen(fired_seen), .full_seen(full_seen));

	always #5 clk = ~clk;

	initial begin
		req.valid = 1'b0; req.func = FN_ADD; req.tag = '0; req.event_value = '0;
		req.time_value = '0; req.target_handle = '0;
		rsp.ready = 1'b0;
	end

	// Result receiver: random stall or long hold-off
	always @(posedge clk) begin
		if (long_hold) rsp.ready <= 1'b0;
		else rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT && !long_hold) begin
			$display("watchdog expired");
			$display("simulation failed");
			$finish;
		end
	end

	// Drive one command and hold it until accepted; valid stays up for the next call
	task automatic send_cmd(logic [2:0] fn, logic [7:0] tg, logic [31:0] val, time_t tv,
		logic [31:0] th);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1; req.func <= fn; req.tag <= tg; req.event_value <= val;
		req.time_value <= tv; req.target_handle <= th;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent++;
	endtask

	// Drop valid after the last command of a burst
	task automatic stop_cmd();
		req.valid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Random command; mostly adds and small advances to keep events flowing
	task automatic random_cmd();
		int r;
		time_t tv;
		logic [2:0] fn;
		r = $urandom_range(99);
		if (r < 40) fn = FN_ADD;
		else if (r < 50) fn = FN_REMOVE;
		else if (r < 62) fn = FN_CANCEL;
		else if (r < 72) fn = FN_ADV_TO;
		else if (r < 96) fn = FN_ADV_BY;
		else fn = 3'($urandom_range(7, 5));
		if ($urandom_range(19) == 0) tv = {$urandom(), $urandom()};
		else tv = time_t'($urandom_range(400));
		if (fn == FN_ADV_TO) tv = tv + chk.sched_now - 48'd100;
		send_cmd(fn, 8'($urandom_range(7)) | ($urandom_range(9) == 0 ? 8'hF8 : 8'h0),
			$urandom(), tv,
			$urandom_range(3) == 0 ? $urandom() : chk.hcnt_model - $urandom_range(12));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ties, cancels, removes, table full, extremes
		send_cmd(FN_ADD, 8'd0, 32'hFFFF_FFFF, 48'd10, 0);
		send_cmd(FN_ADD, 8'hFF, 32'h0, 48'd10, 0);
		send_cmd(FN_ADD, 8'd5, 32'h1234_5678, 48'd5, 0);
		send_cmd(FN_CANCEL, 0, 0, 0, 32'd2);
		send_cmd(FN_CANCEL, 0, 0, 0, 32'd0);
		send_cmd(FN_CANCEL, 0, 0, 0, 32'hFFFF_FFFF);
		send_cmd(FN_ADV_BY, 0, 0, 48'd20, 0);
		send_cmd(FN_ADV_TO, 0, 0, 48'd3, 0);
		for (int i = 0; i < 17; i++) send_cmd(FN_ADD, 8'(i % 3), i, 48'(i * 7), 0);
		send_cmd(FN_CANCEL, 0, 0, 0, 32'd6);
		send_cmd(FN_REMOVE, 8'd1, 0, 0, 0);
		send_cmd(FN_ADD, 8'd9, 32'hA5A5_A5A5, 48'hFFFF_FFFF_FFFF, 0);
		send_cmd(3'd7, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(FN_ADV_TO, 0, 0, 48'd200, 0);
		send_cmd(FN_ADV_BY, 0, 0, 48'hFFFF_FFFF_FFFF, 0);
		stop_cmd();
		drain();

		// Time is now saturated; the only way back is none, so keep advancing small
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 76; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 76; end
				default: begin idle_pct = 34; stall_pct = 34; end
			endcase
			for (int i = 0; i < 22; i++) random_cmd();
		end

		// Receiver holds off while commands keep coming
		idle_pct = 0; stall_pct = 0;
		fork
			begin
				long_hold = 1;
				repeat (300) @(posedge clk);
				long_hold = 0;
			end
			for (int i = 0; i < 12; i++) random_cmd();
		join
		stop_cmd();
		drain();
		repeat (60) @(posedge clk);
		$display("%0d commands sent, %0d events fired, %0d table-full answers",
			sent, fired_seen, full_seen);
		if (errors == 0 && pending == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/teq_pkg.sv
hw/rtl/teq_in_if.sv
hw/rtl/teq_out_if.sv
hw/rtl/teq_cell.sv
hw/rtl/timed_event_queue.sv
hw/rtl/timed_event_queue_chk.sv
tb/sv/teq_tb_chk.sv
tb/sv/timed_event_queue_tb.sv
